FILE: sv/asmb_pkg.sv
// Package with payload types and codes for the adaptive step move builder.
package asmb_pkg;
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_NEXT  = 2'd1;
	localparam logic [1:0] OP_DEST  = 2'd2;
	localparam logic [1:0] OP_SETPOS = 2'd3;

	localparam logic [2:0] V_PENDING   = 3'd0;
	localparam logic [2:0] V_ACCEPTED  = 3'd1;
	localparam logic [2:0] V_TOO_LONG  = 3'd2;
	localparam logic [2:0] V_TOO_SHORT = 3'd3;
	localparam logic [2:0] V_SHORT_FIN = 3'd4;

	localparam logic [2:0] REG_DIR    = 3'd0;
	localparam logic [2:0] REG_LIMIT  = 3'd1;
	localparam logic [2:0] REG_START  = 3'd2;
	localparam logic [2:0] REG_INC    = 3'd3;
	localparam logic [2:0] REG_DMIN   = 3'd4;
	localparam logic [2:0] REG_DMAX   = 3'd5;
	localparam logic [2:0] REG_TARGET = 3'd6;

	typedef struct packed {
		logic [1:0]         operation;
		logic [2:0]         axis;
		logic signed [31:0] position;
		logic               last_axis;
	} in_item_t;

	typedef struct packed {
		logic [31:0] proposed_index;
		logic        limit_reached;
		logic [7:0]  axis_steps;
		logic        axis_negative;
		logic [7:0]  direction_bits;
		logic [31:0] largest_distance;
		logic [2:0]  verdict;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;      // perform the item's work
		logic div_start; // start the rescale divide
		logic finish;    // apply the rescaled increment and the verdict
	} asmb_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} asmb_sts_t;
endpackage

FILE: sv/asmb_ctrl.sv
// Controller state machine sequencing each item through the datapath.
module asmb_ctrl import asmb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  asmb_sts_t sts,
	output asmb_cmd_t cmd
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;

	// A new beat is taken when idle, or when the finished result is leaving.
	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);
	assign cmd.exec = in_valid && in_ready;
	assign cmd.div_start = (state_q == S_DIV);
	assign cmd.finish = (state_q == S_WAIT) && sts.div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q) inside
				S_IDLE, S_OUT: begin
					if (cmd.exec) begin
						state_q <= sts.need_div ? S_DIV : S_OUT;
					end else if (state_q == S_OUT && out_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.div_done) state_q <= S_OUT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/asmb_div.sv
// Restoring divider: 64-bit magnitude by 32-bit magnitude, one bit per cycle.
module asmb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [63:0] quotient
);
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;

	assign busy = (cnt_q != 7'd0);
	assign quotient = quo_q;
	assign trial = {rem_q[31:0], quo_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 33'd0;
			dsr_q <= divisor;
		end else if (busy) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

FILE: sv/asmb_dp.sv
// Datapath: registers, position banks, index proposal, distance tracking and rescale.
module asmb_dp import asmb_pkg::*; #(
	parameter int AXES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  in_item_t    in_item,
	input  asmb_cmd_t   cmd,
	output asmb_sts_t   sts,
	output out_item_t   out_item
);
	localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

	logic               dir_up_q;
	logic [31:0]        limit_q, start_q, sinc_q;
	logic [15:0]        dmin_q, dmax_q, dtgt_q;
	logic signed [31:0] bank_a [AXES];
	logic signed [31:0] bank_b [AXES];
	logic               a_cur_q;
	logic [31:0]        curve_q, pend_q, rmax_q;
	logic signed [31:0] inc_q;
	logic               clamp_q;
	logic [7:0]         rsign_q;
	logic [7:0]         steps_q;
	logic               neg_q;
	logic [2:0]         verdict_q;
	logic               clr_q;
	logic               inc_neg_q;
	logic [47:0]        prod_q;

	logic               in_range;
	logic [AW-1:0]      ai;
	logic signed [31:0] cur;
	logic signed [33:0] cand, after;
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [31:0]        mag_sat, new_max;
	logic [31:0]        rmax_base;
	logic [7:0]         rsign_base;
	logic signed [24:0] tp, tc;
	logic signed [25:0] isteps;
	logic [7:0]         sign_new;
	logic               div_busy;
	logic [63:0]        quo;
	logic [31:0]        inc_mag;
	logic [31:0]        vmax;
	logic [2:0]         verdict_new;
	logic               judge_now;

	assign in_range = ({29'd0, in_item.axis} < 32'(AXES));
	assign ai = AW'(in_item.axis);
	always_comb begin
		cur = 32'sd0;
		if (in_range) cur = a_cur_q ? bank_a[ai] : bank_b[ai];
	end

	// Running values left by a finished last-axis beat read as cleared.
	assign rmax_base = clr_q ? 32'd0 : rmax_q;
	assign rsign_base = clr_q ? 8'd0 : rsign_q;

	assign cand = 34'(signed'({1'b0, curve_q})) + 34'(inc_q);
	assign after = cand + 34'(inc_q);

	assign diff = 33'(in_item.position) - 33'(cur);
	assign mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign mag_sat = mag[32] ? 32'hFFFF_FFFF : mag[31:0];
	assign new_max = (mag_sat > rmax_base) ? mag_sat : rmax_base;
	// Truncation toward zero of Q24.8 positions.
	assign tp = 25'(in_item.position >>> 8) +
		25'((in_item.position[31] && in_item.position[7:0] != 8'd0) ? 1 : 0);
	assign tc = 25'(cur >>> 8) + 25'((cur[31] && cur[7:0] != 8'd0) ? 1 : 0);
	assign isteps = diff[32] ? (26'(tc) - 26'(tp)) : (26'(tp) - 26'(tc));
	always_comb begin
		sign_new = rsign_base;
		if (diff[32] && in_range) sign_new[in_item.axis] = 1'b1;
	end

	assign inc_mag = inc_q[31] ? 32'(-inc_q) : inc_q;
	assign sts.need_div = (in_item.operation == OP_DEST) && in_item.last_axis &&
		(new_max != 32'd0) && (new_max[23:8] != dtgt_q);
	assign sts.div_done = !div_busy;
	assign judge_now = (in_item.operation == OP_DEST) && in_item.last_axis &&
		!sts.need_div;

	// After a rescale the stored maximum is judged, otherwise the one just formed.
	always_comb begin
		vmax = cmd.finish ? rmax_q : new_max;
		if (vmax >= {8'd0, dmax_q, 8'd0} && !clamp_q) begin
			verdict_new = V_TOO_LONG;
		end else if (vmax <= {8'd0, dmin_q, 8'd0}) begin
			verdict_new = clamp_q ? V_SHORT_FIN : V_TOO_SHORT;
		end else begin
			verdict_new = V_ACCEPTED;
		end
	end

	asmb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend({8'd0, prod_q, 8'd0}), .divisor(rmax_q),
		.busy(div_busy), .quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.exec && in_range) begin
			if (in_item.operation == OP_DEST) begin
				if (a_cur_q) bank_b[ai] <= in_item.position;
				else bank_a[ai] <= in_item.position;
			end else if (in_item.operation == OP_SETPOS) begin
				if (a_cur_q) bank_a[ai] <= in_item.position;
				else bank_b[ai] <= in_item.position;
			end
		end
		if (cmd.exec) begin
			prod_q <= 48'(inc_mag) * 48'(dtgt_q);
			steps_q <= (in_item.operation == OP_DEST) ? isteps[7:0] : 8'd0;
			neg_q <= (in_item.operation == OP_DEST) && diff[32];
			inc_neg_q <= inc_q[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_up_q <= 1'b1;
			limit_q <= '0; start_q <= '0; sinc_q <= '0;
			dmin_q <= '0; dmax_q <= '0; dtgt_q <= '0;
			a_cur_q <= 1'b1;
			curve_q <= '0; pend_q <= '0; inc_q <= '0;
			clamp_q <= 1'b1; rmax_q <= '0; rsign_q <= '0;
			verdict_q <= V_PENDING; clr_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIR:    dir_up_q <= cfg_data[0];
					REG_LIMIT:  limit_q <= cfg_data;
					REG_START:  start_q <= cfg_data;
					REG_INC:    sinc_q <= cfg_data;
					REG_DMIN:   dmin_q <= cfg_data[15:0];
					REG_DMAX:   dmax_q <= cfg_data[15:0];
					REG_TARGET: dtgt_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				// A last-axis destination beat with no rescale is judged at once.
				verdict_q <= judge_now ? verdict_new : V_PENDING;
				clr_q <= (in_item.operation == OP_DEST) && in_item.last_axis;
				unique case (in_item.operation)
					OP_BEGIN: begin
						curve_q <= start_q;
						inc_q <= signed'(sinc_q);
						rmax_q <= '0; rsign_q <= '0;
					end
					OP_NEXT: begin
						if (dir_up_q != (after < 34'(signed'({1'b0, limit_q})))) begin
							pend_q <= limit_q; clamp_q <= 1'b1;
						end else begin
							clamp_q <= 1'b0;
							if (cand < 0) pend_q <= '0;
							else if (cand[33:32] != 2'b00) pend_q <= 32'hFFFF_FFFF;
							else pend_q <= cand[31:0];
						end
						rmax_q <= '0; rsign_q <= '0;
					end
					OP_DEST: begin
						rmax_q <= new_max;
						rsign_q <= sign_new;
						if (judge_now && verdict_new == V_ACCEPTED) begin
							a_cur_q <= !a_cur_q;
							curve_q <= pend_q;
						end
					end
					default: begin
						rmax_q <= rmax_base;
						rsign_q <= rsign_base;
					end
				endcase
			end else if (cmd.finish) begin
				if (inc_neg_q) begin
					inc_q <= (quo > 64'd2147483648) ? 32'sh8000_0000 : 32'(-quo);
				end else begin
					inc_q <= (quo > 64'd2147483647) ? 32'sh7FFF_FFFF : quo[31:0];
				end
				verdict_q <= verdict_new;
				if (verdict_new == V_ACCEPTED) begin
					a_cur_q <= !a_cur_q;
					curve_q <= pend_q;
				end
			end
		end
	end

	assign out_item.proposed_index = pend_q;
	assign out_item.limit_reached = clamp_q;
	assign out_item.axis_steps = steps_q;
	assign out_item.axis_negative = neg_q;
	assign out_item.direction_bits = rsign_q;
	assign out_item.largest_distance = rmax_q;
	assign out_item.verdict = verdict_q;
endmodule

FILE: sv/adaptive_step_move_builder.sv
// Top level of the adaptive step move builder.
// One result beat follows every input beat on a valid/ready channel pair.
// Operations: begin, next index, axis destination, set current position.
// Begin, next, set-position and ordinary destination beats present their
// result in the cycle after acceptance.
// A last-axis destination that needs an increment rescale runs a 64-step
// restoring divider, one quotient bit a cycle; the result appears once the
// divider is no longer busy.
// A new input beat is taken in the same cycle the waiting result leaves.
// While the receiver stalls, the result is held and no further input is taken.
// The user writes configuration registers (cfg_we, cfg_index, cfg_data)
// only while no beat is in flight; the block itself does not enforce it.
// Reset sets the state and configuration registers to their defaults; the
// position banks, step outputs and divider data are not reset.
module adaptive_step_move_builder import asmb_pkg::*; #(
	parameter int AXES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	asmb_cmd_t cmd;
	asmb_sts_t sts;

	asmb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	asmb_dp #(.AXES(AXES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_data), .cmd(cmd), .sts(sts),
		.out_item(out_data)
	);
endmodule
